// ----- hdl/wheel_speed_odometer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Wheel speed odometer core: assertion macros
// Shared concurrent assertion forms used by the core's RTL.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_ODOMETER_CORE_DEFINES_SVH
`define WHEEL_SPEED_ODOMETER_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define WSO_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("wso: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define WSO_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wso: implication violated");

`endif

// ----- hdl/wso_pkg.sv -----
// ----------------------------------------------------------------------------
// Wheel speed odometer package
// Widths, constants, payload types and control codes shared by the core.
// ----------------------------------------------------------------------------
package wso_pkg;

	// Field and register widths
	localparam int TIME_W   = 32;
	localparam int SPEED_W  = 16;
	localparam int DIST_W   = 30;
	localparam int CIRC_W   = 12;
	localparam int DEB_W    = 16;
	localparam int STOP_W   = 16;
	localparam int STEP_W   = 16;
	localparam int CFG_W    = 30;
	localparam int CFG_IDX_W = 3;

	// Distance accumulator in 1/360 mm units
	localparam int ACC_W = 49;
	localparam logic [ACC_W-1:0] ACC_MAX = 49'd360000000000000;
	localparam logic [18:0] UNITS_PER_M = 19'd360000;
	localparam logic [DIST_W-1:0] DIST_MAX = 30'd1000000000;

	// Speed divide: dividend is circumference times 360
	localparam logic [8:0] SPEED_K = 9'd360;
	localparam int DIVD_W = CIRC_W + 9;
	localparam int PROD_W = SPEED_W + TIME_W;

	// Metre conversion: 360000 = 64 * 5625
	localparam int CONV_SHIFT = 6;
	localparam int CONV_IN_W  = ACC_W - CONV_SHIFT;
	localparam int CONV_STEPS = (CONV_IN_W + 1) / 2;
	localparam int CONV_X_W   = 2 * CONV_STEPS;
	localparam int CONV_REM_W = 13;
	localparam logic [CONV_REM_W:0] CONV_DIV = 14'd5625;

	// Reset values of the configuration registers
	localparam logic [DEB_W-1:0]  DEB_RST   = 16'd50;
	localparam logic [CIRC_W-1:0] CIRC_RST  = 12'd2100;
	localparam logic [STOP_W-1:0] STOP_RST  = 16'd2000;
	localparam logic [STEP_W-1:0] STEP_RST  = 16'd100;
	localparam logic [DIST_W-1:0] START_RST = 30'd0;

	typedef struct packed {
		logic              pin_level;
		logic [31:0]       time_ms;
	} in_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_centi_kmh;
		logic [DIST_W-1:0]  distance_m;
		logic               save_now;
	} out_item_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_CIRC      = 3'd1,
		REG_STOP      = 3'd2,
		REG_SAVE_STEP = 3'd3,
		REG_START     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TMO,
		ST_MUL,
		ST_SAVE,
		ST_CNV_GO,
		ST_CNV,
		ST_DONE
	} state_t;

	// Status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ----- hdl/wso_div.sv -----
// ----------------------------------------------------------------------------
// Wheel speed odometer speed divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wso_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [wso_pkg::DIVD_W-1:0]        dividend,
	input  logic [wso_pkg::TIME_W-1:0]        divisor,
	output logic [wso_pkg::DIVD_W-1:0]        quot,
	output wso_pkg::unit_stat_t               stat
);

	localparam int DW    = wso_pkg::DIVD_W;
	localparam int TW    = wso_pkg::TIME_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [TW:0]      rem_q;
	logic [TW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TW:0] rem_sh;
	logic        ge;
	logic [TW:0] rem_nx;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh = {rem_q[TW-1:0], dvd_q[DW-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend register turns into the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign quot      = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/wso_mul.sv -----
// ----------------------------------------------------------------------------
// Wheel speed odometer distance multiplier
// Shift-add multiplier of speed by elapsed time, one speed bit per cycle.
// ----------------------------------------------------------------------------
module wso_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [wso_pkg::SPEED_W-1:0]       mcand,
	input  logic [wso_pkg::TIME_W-1:0]        mplier,
	output logic [wso_pkg::PROD_W-1:0]        prod,
	output wso_pkg::unit_stat_t               stat
);

	localparam int SW    = wso_pkg::SPEED_W;
	localparam int TW    = wso_pkg::TIME_W;
	localparam int PW    = wso_pkg::PROD_W;
	localparam int CNT_W = $clog2(SW + 1);

	logic [PW-1:0]    p_q;
	logic [TW-1:0]    dt_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TW:0] hi_sum;

	// Add the time operand into the upper half when the low bit is set
	always_comb begin
		hi_sum = {1'b0, p_q[PW-1:SW]} + (p_q[0] ? {1'b0, dt_q} : '0);
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift right, partial sum enters from the top
	always_ff @(posedge clk) begin
		if (start) begin
			p_q  <= {{TW{1'b0}}, mcand};
			dt_q <= mplier;
		end else if (busy_q) begin
			p_q <= {hi_sum, p_q[SW-1:1]};
		end
	end

	assign prod      = p_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/wso_conv.sv -----
// ----------------------------------------------------------------------------
// Wheel speed odometer metre converter
// Divides the accumulator by 360000, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module wso_conv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [wso_pkg::ACC_W-1:0]         acc,
	output logic [wso_pkg::DIST_W-1:0]        dist_m,
	output wso_pkg::unit_stat_t               stat
);

	localparam int XW    = wso_pkg::CONV_X_W;
	localparam int RW    = wso_pkg::CONV_REM_W;
	localparam int CNT_W = $clog2(wso_pkg::CONV_STEPS + 1);

	logic [XW-1:0]    x_q;
	logic [RW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW:0] r1;
	logic        g1;
	logic [RW:0] r1_nx;
	logic [RW:0] r2;
	logic        g2;
	logic [RW:0] r2_nx;

	// Two chained compare-subtract steps against the odd factor 5625
	always_comb begin
		r1    = {rem_q, x_q[XW-1]};
		g1    = r1 >= wso_pkg::CONV_DIV;
		r1_nx = g1 ? (r1 - wso_pkg::CONV_DIV) : r1;
		r2    = {r1_nx[RW-1:0], x_q[XW-2]};
		g2    = r2 >= wso_pkg::CONV_DIV;
		r2_nx = g2 ? (r2 - wso_pkg::CONV_DIV) : r2;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(wso_pkg::CONV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: drop the factor 64 by shift, then long-divide by 5625
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= XW'(acc[wso_pkg::ACC_W-1:wso_pkg::CONV_SHIFT]);
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[XW-3:0], g1, g2};
			rem_q <= r2_nx[RW-1:0];
		end
	end

	assign dist_m    = x_q[wso_pkg::DIST_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/wheel_speed_odometer_core.sv -----
// Each input transfer passes the stop timeout and the metre conversion; an
// accepted trigger adds a bit-serial speed divide, integrating distance adds a
// serial 16-step multiply, and the first sample skips the save test.
// One sample in flight at a time: a new sample waits until the result is loaded.
// Reset: control, odometer and configuration state return to defaults, no
// clearing pass; payload registers and unit datapaths are not reset.
// ----------------------------------------------------------------------------
// Wheel speed odometer core
// Hall sensor edge timing to speed, integrated distance and save pulses.
// ----------------------------------------------------------------------------
`include "wheel_speed_odometer_core_defines.svh"

module wheel_speed_odometer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  wso_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output wso_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wso_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wso_pkg::CFG_W-1:0]         cfg_data
);

	localparam int TW = wso_pkg::TIME_W;
	localparam int AW = wso_pkg::ACC_W;
	localparam int SW = wso_pkg::SPEED_W;

	// Configuration registers
	logic [wso_pkg::DEB_W-1:0]  debounce_q;
	logic [wso_pkg::CIRC_W-1:0] circ_q;
	logic [wso_pkg::STOP_W-1:0] stop_q;
	logic [wso_pkg::STEP_W-1:0] step_q;
	logic [wso_pkg::DIST_W-1:0] start_q;

	// Block state
	wso_pkg::state_t state_q, state_nx;
	logic           prev_level_q;
	logic [TW-1:0]  last_trig_q;
	logic [TW-1:0]  last_samp_q;
	logic           have_q;
	logic [SW-1:0]  speed_q;
	logic [AW-1:0]  acc_q;
	logic [AW-1:0]  saved_q;
	logic [TW-1:0]  now_q;
	logic           save_q;
	logic [AW-1:0]  step_units_q;
	logic           out_valid_q;
	wso_pkg::out_item_t out_q;

	// Unit hookup
	logic                          div_start, mul_start, conv_start;
	logic [wso_pkg::DIVD_W-1:0]    div_quot;
	logic [wso_pkg::PROD_W-1:0]    mul_prod;
	logic [wso_pkg::DIST_W-1:0]    conv_dist;
	wso_pkg::unit_stat_t           div_stat, mul_stat, conv_stat;

	// Combinational datapath terms
	logic [TW-1:0]                 in_time;
	logic [TW-1:0]                 period;
	logic                          trig_ok;
	logic [wso_pkg::DIVD_W-1:0]    div_dvd;
	logic [SW-1:0]                 speed_sat;
	logic [TW-1:0]                 tmo_diff;
	logic [SW-1:0]                 speed_nx;
	logic [wso_pkg::DIST_W-1:0]    start_c;
	logic [AW-1:0]                 start_units;
	logic [AW:0]                   acc_sum;
	logic [AW-1:0]                 acc_sat;
	logic [AW-1:0]                 acc_gain;
	logic                          out_load;

	// Edge detect, debounce and divider operands
	always_comb begin
		in_time  = in_data.time_ms[TW-1:0];
		period   = in_time - last_trig_q;
		trig_ok  = !in_data.pin_level && prev_level_q && (period > TW'(debounce_q));
		div_dvd  = wso_pkg::DIVD_W'(circ_q) * wso_pkg::DIVD_W'(wso_pkg::SPEED_K);
		speed_sat = (|div_quot[wso_pkg::DIVD_W-1:SW]) ? '1 : div_quot[SW-1:0];
	end

	// Stop timeout, start distance and saturating accumulate
	always_comb begin
		tmo_diff    = now_q - last_trig_q;
		speed_nx    = (tmo_diff > TW'(stop_q)) ? '0 : speed_q;
		start_c     = (start_q > wso_pkg::DIST_MAX) ? wso_pkg::DIST_MAX : start_q;
		start_units = AW'(start_c) * AW'(wso_pkg::UNITS_PER_M);
		acc_sum     = {1'b0, acc_q} + (AW + 1)'(mul_prod);
		acc_sat     = (acc_sum > {1'b0, wso_pkg::ACC_MAX}) ? wso_pkg::ACC_MAX
			: acc_sum[AW-1:0];
		acc_gain    = acc_q - saved_q;
		out_load    = (state_q == wso_pkg::ST_DONE) && (!out_valid_q || out_ready);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			wso_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = trig_ok ? wso_pkg::ST_DIV : wso_pkg::ST_TMO;
				end
			end
			wso_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_nx = wso_pkg::ST_TMO;
				end
			end
			wso_pkg::ST_TMO: begin
				if (!have_q) begin
					state_nx = wso_pkg::ST_CNV_GO;
				end else if (speed_nx != '0) begin
					state_nx = wso_pkg::ST_MUL;
				end else begin
					state_nx = wso_pkg::ST_SAVE;
				end
			end
			wso_pkg::ST_MUL: begin
				if (mul_stat.done) begin
					state_nx = wso_pkg::ST_SAVE;
				end
			end
			wso_pkg::ST_SAVE:   state_nx = wso_pkg::ST_CNV_GO;
			wso_pkg::ST_CNV_GO: state_nx = wso_pkg::ST_CNV;
			wso_pkg::ST_CNV: begin
				if (conv_stat.done) begin
					state_nx = wso_pkg::ST_DONE;
				end
			end
			wso_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nx = wso_pkg::ST_IDLE;
				end
			end
			default: state_nx = wso_pkg::ST_IDLE;
		endcase
	end

	// State outputs: handshake and unit starts
	always_comb begin
		in_ready   = 1'b0;
		div_start  = 1'b0;
		mul_start  = 1'b0;
		conv_start = 1'b0;
		unique case (state_q)
			wso_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && trig_ok;
			end
			wso_pkg::ST_TMO:    mul_start  = have_q && (speed_nx != '0);
			wso_pkg::ST_CNV_GO: conv_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wso_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= wso_pkg::DEB_RST;
			circ_q     <= wso_pkg::CIRC_RST;
			stop_q     <= wso_pkg::STOP_RST;
			step_q     <= wso_pkg::STEP_RST;
			start_q    <= wso_pkg::START_RST;
		end else if (cfg_valid) begin
			unique case (wso_pkg::cfg_reg_t'(cfg_index))
				wso_pkg::REG_DEBOUNCE:  debounce_q <= cfg_data[wso_pkg::DEB_W-1:0];
				wso_pkg::REG_CIRC:      circ_q     <= cfg_data[wso_pkg::CIRC_W-1:0];
				wso_pkg::REG_STOP:      stop_q     <= cfg_data[wso_pkg::STOP_W-1:0];
				wso_pkg::REG_SAVE_STEP: step_q     <= cfg_data[wso_pkg::STEP_W-1:0];
				wso_pkg::REG_START:     start_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Odometer state: edge tracking, speed, distance and save point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			last_trig_q  <= '0;
			last_samp_q  <= '0;
			have_q       <= 1'b0;
			speed_q      <= '0;
			acc_q        <= '0;
			saved_q      <= '0;
			save_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				wso_pkg::ST_IDLE: begin
					if (in_valid) begin
						prev_level_q <= in_data.pin_level;
						save_q       <= 1'b0;
						if (trig_ok) begin
							last_trig_q <= in_time;
						end
					end
				end
				wso_pkg::ST_DIV: begin
					if (div_stat.done) begin
						speed_q <= speed_sat;
					end
				end
				wso_pkg::ST_TMO: begin
					speed_q     <= speed_nx;
					last_samp_q <= now_q;
					if (!have_q) begin
						acc_q   <= start_units;
						saved_q <= start_units;
						have_q  <= 1'b1;
					end
				end
				wso_pkg::ST_MUL: begin
					if (mul_stat.done) begin
						acc_q <= acc_sat;
					end
				end
				wso_pkg::ST_SAVE: begin
					if (acc_gain >= step_units_q) begin
						save_q  <= 1'b1;
						saved_q <= acc_q;
					end
				end
				default: ;
			endcase

			// Hold the result until it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == wso_pkg::ST_IDLE) && in_valid) begin
			now_q <= in_time;
		end
		if (state_q == wso_pkg::ST_TMO) begin
			step_units_q <= AW'(step_q) * AW'(wso_pkg::UNITS_PER_M);
		end
		if (out_load) begin
			out_q.speed_centi_kmh <= speed_q;
			out_q.distance_m      <= conv_dist;
			out_q.save_now        <= save_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	wso_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (period),
		.quot     (div_quot),
		.stat     (div_stat)
	);

	wso_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (speed_nx),
		.mplier (now_q - last_samp_q),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	wso_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.acc    (acc_q),
		.dist_m (conv_dist),
		.stat   (conv_stat)
	);

	// Checks
	`WSO_ASSERT_ALWAYS(a_acc_bound, clk, arst_n, acc_q <= wso_pkg::ACC_MAX)
	`WSO_ASSERT_ALWAYS(a_saved_le_acc, clk, arst_n, saved_q <= acc_q)
	`WSO_ASSERT_IMPLY(a_div_idle, clk, arst_n, div_start, !div_stat.busy)
	`WSO_ASSERT_IMPLY(a_mul_idle, clk, arst_n, mul_start, !mul_stat.busy)
	`WSO_ASSERT_IMPLY(a_conv_idle, clk, arst_n, conv_start, !conv_stat.busy)
	`WSO_ASSERT_IMPLY(a_conv_done, clk, arst_n, conv_stat.done, state_q == wso_pkg::ST_CNV)

endmodule
